// File: hw/rtl/sph_dp_pkg.sv
// Package for the SPH density and pressure block.
// Holds widths, reset values, register indexes and saturation cap codes.
`default_nettype none
package sph_dp_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int SUM_W         = 48;

    localparam logic [CFG_IDX_W-1:0] REG_MASS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IHR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IRD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TAIT  = 3'd4;

    localparam logic [31:0] MASS_RST  = 32'd65536;
    localparam logic [31:0] IHR_RST   = 32'd655360;
    localparam logic [31:0] COEFF_RST = 32'd5215189;
    localparam logic [31:0] IRD_RST   = 32'd1075646;
    localparam logic [30:0] TAIT_RST  = 31'd934571540;

    typedef enum logic [1:0] {
        CAP_MAX = 2'd0,
        CAP_SUM = 2'd1,
        CAP_POW = 2'd2,
        CAP_P31 = 2'd3
    } cap_t;

    localparam logic [63:0] CAP_MAX_VAL = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] CAP_SUM_VAL = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [63:0] CAP_POW_VAL = 64'h4000_0000_0000_0000;
    localparam logic [63:0] CAP_P31_VAL = 64'h0000_0000_7FFF_FFFF;
endpackage
`default_nettype wire

// File: hw/rtl/sph_dp_if.sv
// Request channel interfaces of the SPH density and pressure block.
// Depends on nothing.
`default_nettype none
interface sph_dp_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] neighbor_dist;
    logic        has_neighbor;
    logic        last_neighbor;
    modport source (output valid, neighbor_dist, has_neighbor, last_neighbor, input ready);
    modport sink (input valid, neighbor_dist, has_neighbor, last_neighbor, output ready);
endinterface

interface sph_dp_out_if;
    logic               valid;
    logic               ready;
    logic        [31:0] density;
    logic        [31:0] inv_density;
    logic signed [31:0] pressure;
    logic               density_zero;
    modport source (output valid, density, inv_density, pressure, density_zero, input ready);
    modport sink (input valid, density, inv_density, pressure, density_zero, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/sph_density_pressure_top.sv
// Top level of the SPH density and Tait pressure block.
// Depends on sph_dp_pkg and the interfaces in sph_dp_if.
//
// Channel   Dir  Payload
// in_ch     in   neighbor_dist, has_neighbor, last_neighbor
// out_ch    out  density, inv_density, pressure, density_zero
// cfg       in   cfg_we, cfg_index, cfg_data
//
// All products run through one 32x32 multiplier.
// A neighbor kernel takes seven products inside half the radius, five out to
// the full radius and one beyond it; the first request of a particle also
// evaluates the self term. Closing a particle costs a serial divide to a
// FRAC_BITS+31 bit quotient plus six products.
// The block takes no request until its result is taken. Reset is asynchronous.
`default_nettype none
module sph_density_pressure_top import sph_dp_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    sph_dp_in_if.sink                  in_ch,
    sph_dp_out_if.source               out_ch,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);
    localparam logic [63:0] ONE_Q = 64'(1) << FRAC_BITS;
    localparam logic [63:0] TWO_Q = ONE_Q << 1;
    localparam int QW = 31 + FRAC_BITS;
    localparam int CW = $clog2(QW);
    localparam logic [CW-1:0] DIV_LAST = CW'(QW - 1);

    typedef enum logic [20:0] {
        S_IDLE = 21'h000001, S_KQ   = 21'h000002, S_KT   = 21'h000004,
        S_KT3  = 21'h000008, S_KU   = 21'h000010, S_KU3  = 21'h000020,
        S_KU4  = 21'h000040, S_KW   = 21'h000080, S_KM   = 21'h000100,
        S_KADD = 21'h000200, S_FIN  = 21'h000400, S_DIV  = 21'h000800,
        S_R2   = 21'h001000, S_R4   = 21'h002000, S_R6   = 21'h004000,
        S_R7   = 21'h008000, S_P    = 21'h010000, S_PEND = 21'h020000,
        S_OUT  = 21'h040000, S_MUL  = 21'h080000, S_MULF = 21'h100000
    } state_t;

    logic [31:0] mass_reg, ihr_reg, coeff_reg, ird_reg;
    logic [30:0] tait_reg;

    state_t state_reg, state_next, ret_reg, ret_next;
    logic open_reg, open_next, self_reg, self_next;
    logic has_reg, has_next, last_reg, last_next;
    logic [31:0] dist_reg, dist_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [63:0] a_reg, a_next, b_reg, b_next;
    logic sh30_reg, sh30_next;
    cap_t cap_reg, cap_next;
    logic [127:0] acc_reg, acc_next;
    logic [63:0] pp_reg, pp_next;
    logic [1:0] ppsh_reg, ppsh_next;
    logic [2:0] mcnt_reg, mcnt_next;
    logic [63:0] mres_reg, mres_next;
    logic [63:0] q_reg, q_next, t_reg, t_next, poly_reg, poly_next;
    logic [63:0] r_reg, r_next, r2_reg, r2_next;
    logic neg_reg, neg_next;
    logic [31:0] dens_reg, dens_next;
    logic [32:0] rem_reg, rem_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic [CW-1:0] dcnt_reg, dcnt_next;
    logic out_valid_reg, out_valid_next;
    logic [31:0] o_dens_reg, o_dens_next, o_inv_reg, o_inv_next, o_pres_reg, o_pres_next;
    logic o_zero_reg, o_zero_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mass_reg  <= MASS_RST;
            ihr_reg   <= IHR_RST;
            coeff_reg <= COEFF_RST;
            ird_reg   <= IRD_RST;
            tait_reg  <= TAIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MASS:  mass_reg  <= cfg_data;
                REG_IHR:   ihr_reg   <= cfg_data;
                REG_COEFF: coeff_reg <= cfg_data;
                REG_IRD:   ird_reg   <= cfg_data;
                REG_TAIT:  tait_reg  <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    logic         go;
    logic [63:0]  op_a, op_b;
    logic         op_30;
    cap_t         op_cap;
    state_t       op_ret;
    logic [31:0]  ah, bh;
    logic [127:0] ppx, shv;
    logic [63:0]  capv, sum_ext, r7v;
    logic [48:0]  sum_add;
    logic [32:0]  rem_sh;
    logic         qbit;
    logic [QW-1:0] quo_sh;
    logic [63:0]  u4;

    always_comb
    begin
        state_next = state_reg; ret_next = ret_reg;
        open_next = open_reg; self_next = self_reg;
        has_next = has_reg; last_next = last_reg; dist_next = dist_reg;
        sum_next = sum_reg;
        a_next = a_reg; b_next = b_reg; sh30_next = sh30_reg; cap_next = cap_reg;
        acc_next = acc_reg; pp_next = pp_reg; ppsh_next = ppsh_reg; mcnt_next = mcnt_reg;
        mres_next = mres_reg;
        q_next = q_reg; t_next = t_reg; poly_next = poly_reg;
        r_next = r_reg; r2_next = r2_reg; neg_next = neg_reg;
        dens_next = dens_reg; rem_next = rem_reg; quo_next = quo_reg; dcnt_next = dcnt_reg;
        out_valid_next = out_valid_reg;
        o_dens_next = o_dens_reg; o_inv_next = o_inv_reg;
        o_pres_next = o_pres_reg; o_zero_next = o_zero_reg;
        go = 1'b0; op_a = '0; op_b = '0; op_30 = 1'b0; op_cap = CAP_MAX; op_ret = S_IDLE;

        ah = mcnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
        bh = mcnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
        case (ppsh_reg)
            2'd0:    ppx = {64'd0, pp_reg};
            2'd1:    ppx = {32'd0, pp_reg, 32'd0};
            default: ppx = {pp_reg, 64'd0};
        endcase
        shv = sh30_reg ? (acc_reg >> 30) : (acc_reg >> FRAC_BITS);
        case (cap_reg)
            CAP_MAX: capv = CAP_MAX_VAL;
            CAP_SUM: capv = CAP_SUM_VAL;
            CAP_POW: capv = CAP_POW_VAL;
            default: capv = CAP_P31_VAL;
        endcase
        sum_add = {1'b0, sum_reg} + {1'b0, mres_reg[SUM_W-1:0]};
        sum_ext = {16'd0, sum_reg};
        r7v = mres_reg;
        rem_sh = {rem_reg[31:0], (dcnt_reg == '0)};
        qbit = (rem_sh >= {1'b0, dens_reg});
        quo_sh = {quo_reg[QW-2:0], qbit};
        u4 = mres_reg << 2;

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    dist_next = in_ch.neighbor_dist;
                    has_next = in_ch.has_neighbor;
                    last_next = in_ch.last_neighbor;
                    if (!open_reg)
                    begin
                        sum_next = '0;
                        open_next = 1'b1;
                        self_next = 1'b1;
                        state_next = S_KQ;
                    end
                    else if (in_ch.has_neighbor)
                    begin
                        self_next = 1'b0;
                        state_next = S_KQ;
                    end
                    else if (in_ch.last_neighbor)
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_KQ:
            begin
                go = 1'b1;
                op_a = self_reg ? 64'd0 : {32'd0, dist_reg};
                op_b = {32'd0, ihr_reg};
                op_ret = S_KT;
            end
            S_KT:
            begin
                q_next = mres_reg;
                if (mres_reg >= TWO_Q)
                begin
                    mres_next = '0;
                    state_next = S_KADD;
                end
                else
                begin
                    t_next = TWO_Q - mres_reg;
                    go = 1'b1;
                    op_a = TWO_Q - mres_reg;
                    op_b = TWO_Q - mres_reg;
                    op_ret = S_KT3;
                end
            end
            S_KT3:
            begin
                go = 1'b1;
                op_a = mres_reg;
                op_b = t_reg;
                op_ret = S_KU;
            end
            S_KU:
            begin
                poly_next = mres_reg;
                if (q_reg < ONE_Q)
                begin
                    t_next = ONE_Q - q_reg;
                    go = 1'b1;
                    op_a = ONE_Q - q_reg;
                    op_b = ONE_Q - q_reg;
                    op_ret = S_KU3;
                end
                else
                begin
                    state_next = S_KW;
                end
            end
            S_KU3:
            begin
                go = 1'b1;
                op_a = mres_reg;
                op_b = t_reg;
                op_ret = S_KU4;
            end
            S_KU4:
            begin
                poly_next = (u4 >= poly_reg) ? 64'd0 : poly_reg - u4;
                state_next = S_KW;
            end
            S_KW:
            begin
                go = 1'b1;
                op_a = {32'd0, coeff_reg};
                op_b = poly_reg;
                op_ret = S_KM;
            end
            S_KM:
            begin
                go = 1'b1;
                op_a = {32'd0, mass_reg};
                op_b = mres_reg;
                op_cap = CAP_SUM;
                op_ret = S_KADD;
            end
            S_KADD:
            begin
                sum_next = sum_add[SUM_W] ? CAP_SUM_VAL[SUM_W-1:0] : sum_add[SUM_W-1:0];
                if (self_reg && has_reg)
                begin
                    self_next = 1'b0;
                    state_next = S_KQ;
                end
                else
                begin
                    self_next = 1'b0;
                    state_next = last_reg ? S_FIN : S_IDLE;
                end
            end
            S_FIN:
            begin
                open_next = 1'b0;
                if (sum_reg == '0)
                begin
                    o_dens_next = '0; o_inv_next = '0; o_pres_next = '0;
                    o_zero_next = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    dens_next = (sum_ext[47:32] != '0) ? 32'hFFFF_FFFF : sum_reg[31:0];
                    sum_next = '0;
                    rem_next = '0;
                    quo_next = '0;
                    dcnt_next = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next = qbit ? rem_sh - {1'b0, dens_reg} : rem_sh;
                quo_next = quo_sh;
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DIV_LAST)
                begin
                    o_inv_next = (quo_sh[QW-1:32] != '0) ? 32'hFFFF_FFFF : quo_sh[31:0];
                    go = 1'b1;
                    op_a = {32'd0, dens_reg};
                    op_b = {32'd0, ird_reg};
                    op_30 = 1'b1;
                    op_cap = CAP_POW;
                    op_ret = S_R2;
                end
            end
            S_R2:
            begin
                r_next = mres_reg;
                go = 1'b1; op_a = mres_reg; op_b = mres_reg;
                op_cap = CAP_POW; op_ret = S_R4;
            end
            S_R4:
            begin
                r2_next = mres_reg;
                go = 1'b1; op_a = mres_reg; op_b = mres_reg;
                op_cap = CAP_POW; op_ret = S_R6;
            end
            S_R6:
            begin
                go = 1'b1; op_a = mres_reg; op_b = r2_reg;
                op_cap = CAP_POW; op_ret = S_R7;
            end
            S_R7:
            begin
                go = 1'b1; op_a = mres_reg; op_b = r_reg;
                op_cap = CAP_POW; op_ret = S_P;
            end
            S_P:
            begin
                go = 1'b1;
                op_a = {33'd0, tait_reg};
                op_ret = S_PEND;
                if (r7v >= ONE_Q)
                begin
                    neg_next = 1'b0;
                    op_b = r7v - ONE_Q;
                    op_cap = CAP_P31;
                end
                else
                begin
                    neg_next = 1'b1;
                    op_b = ONE_Q - r7v;
                end
            end
            S_PEND:
            begin
                o_dens_next = dens_reg;
                o_pres_next = neg_reg ? 32'd0 - mres_reg[31:0] : mres_reg[31:0];
                o_zero_next = 1'b0;
                out_valid_next = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ch.ready)
                begin
                    out_valid_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            S_MUL:
            begin
                if (mcnt_reg != 3'd4)
                begin
                    pp_next = {32'd0, ah} * {32'd0, bh};
                    ppsh_next = {1'b0, mcnt_reg[1]} + {1'b0, mcnt_reg[0]};
                end
                else
                begin
                    state_next = S_MULF;
                end
                if (mcnt_reg != 3'd0)
                begin
                    acc_next = acc_reg + ppx;
                end
                mcnt_next = mcnt_reg + 3'd1;
            end
            S_MULF:
            begin
                mres_next = ((shv[127:64] != '0) || (shv[63:0] > capv)) ? capv : shv[63:0];
                state_next = ret_reg;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (go)
        begin
            a_next = op_a; b_next = op_b; sh30_next = op_30; cap_next = op_cap;
            ret_next = op_ret; acc_next = '0; mcnt_next = '0;
            state_next = S_MUL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg <= S_IDLE;
            open_reg <= 1'b0;
            self_reg <= 1'b0;
            sum_reg <= '0;
            mcnt_reg <= '0;
            dcnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg <= ret_next;
            open_reg <= open_next;
            self_reg <= self_next;
            sum_reg <= sum_next;
            mcnt_reg <= mcnt_next;
            dcnt_reg <= dcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        has_reg <= has_next; last_reg <= last_next; dist_reg <= dist_next;
        a_reg <= a_next; b_reg <= b_next; sh30_reg <= sh30_next; cap_reg <= cap_next;
        acc_reg <= acc_next; pp_reg <= pp_next; ppsh_reg <= ppsh_next;
        mres_reg <= mres_next;
        q_reg <= q_next; t_reg <= t_next; poly_reg <= poly_next;
        r_reg <= r_next; r2_reg <= r2_next; neg_reg <= neg_next;
        dens_reg <= dens_next; rem_reg <= rem_next; quo_reg <= quo_next;
        o_dens_reg <= o_dens_next; o_inv_reg <= o_inv_next;
        o_pres_reg <= o_pres_next; o_zero_reg <= o_zero_next;
    end

    assign in_ch.ready = (state_reg == S_IDLE);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.density = o_dens_reg;
    assign out_ch.inv_density = o_inv_reg;
    assign out_ch.pressure = o_pres_reg;
    assign out_ch.density_zero = o_zero_reg;
endmodule
`default_nettype wire

// File: hw/rtl/sph_dp_chk.sv
// Port checker for the SPH density and pressure block, bound to the top level.
// Depends on nothing but the top level's ports.
`default_nettype none
module sph_dp_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] density,
    input wire logic [31:0] inv_density,
    input wire logic [31:0] pressure,
    input wire logic        density_zero
);
    // The block never takes a request while a result is pending.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("request taken while result pending");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && density_zero) |->
        (density == 32'd0 && inv_density == 32'd0 && pressure == 32'd0))
        else $error("zero density result not cleared");

    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !density_zero) |-> (density != 32'd0 && inv_density != 32'd0))
        else $error("nonzero result with zero density");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(density) && $stable(pressure)))
        else $error("result dropped while stalled");

    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) |=> !out_valid) else $error("result repeated");
endmodule

bind sph_density_pressure_top sph_dp_chk u_chk (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .density(out_ch.density),
    .inv_density(out_ch.inv_density),
    .pressure(out_ch.pressure),
    .density_zero(out_ch.density_zero)
);
`default_nettype wire
